// ===== hw/rtl/time_of_day_keeper_unit_assert.svh =====
// Assertion macros for the time of day keeper.
`ifndef TIME_OF_DAY_KEEPER_UNIT_ASSERT_SVH
`define TIME_OF_DAY_KEEPER_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define TODK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TODK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TODK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/todk_pkg.sv =====
// Constants and types for the time of day keeper.
package todk_pkg;

    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;
    localparam int ROUND_UP_SECOND = 30;
    localparam int HOURS_PER_DAY   = 24;
    localparam int HOURS_PER_HALF  = 12;

    localparam int NSTG = 6;

    localparam logic [1:0] OP_LOAD_HMS = 2'd0;
    localparam logic [1:0] OP_LOAD_CNT = 2'd1;
    localparam logic [1:0] OP_ADVANCE  = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // Seconds-per-day divide: drop the power of two, then multiply by a
    // floor reciprocal of the odd part; estimate is low by at most one.
    localparam int DAY_PRE_SHIFT = 7;
    localparam int DAY_ODD_DIV   = SECS_PER_DAY / (2 ** DAY_PRE_SHIFT);
    localparam int DAY_DIV_SHIFT = 34;
    localparam logic [24:0] DAY_RECIP =
        25'((64'd1 << DAY_DIV_SHIFT) / 64'(DAY_ODD_DIV));

    // Divide by 60: ceiling reciprocal, exact for values below one day.
    localparam int MIN_DIV_SHIFT = 23;
    localparam logic [17:0] MIN_RECIP =
        18'(((64'd1 << MIN_DIV_SHIFT) + 64'(SECS_PER_MINUTE - 1)) / 64'(SECS_PER_MINUTE));

    // Most negative advance that can still land at or after midnight.
    localparam logic signed [31:0] SUB_LIMIT = 32'(1 - SECS_PER_DAY);

    typedef enum logic [2:0] {
        KIND_HOLD     = 3'd0,
        KIND_LOAD_HMS = 3'd1,
        KIND_LOAD     = 3'd2,
        KIND_ADD      = 3'd3,
        KIND_SUB      = 3'd4
    } step_kind_t;

endpackage

// ===== hw/rtl/time_of_day_keeper_unit.sv =====
// Time of day keeper: pipelined h:m:s counter with load, count load and advance.
//
// Input channel s_*: one word carries an operation, h:m:s load fields and a
// signed 32-bit amount. Operation 0 loads h:m:s (out-of-range fields read as
// zero), 1 loads a seconds count, 2 advances by the amount, 3 keeps the time.
// Negative counts and totals clamp to midnight; others wrap at one day.
// Output channel m_*: one word per input word, in order: the new time, the
// seconds since midnight and a rounded 12-hour view with an after-noon flag.
// A word passes through stage registers p0 to p4 and then the time registers;
// a final register forms the outputs. Throughput: one word per cycle while
// the receiver keeps m_ready high. The amount is reduced and split into h:m:s
// in five pipeline stages that do not depend on the current time; the time
// registers then take a mixed-radix add or subtract, so back to back advances chain without stalls.
// Reset (aresetn low, synchronous) empties the pipeline and sets the time
// to 23:59:59. When the receiver stalls, words keep moving into empty
// stages; s_ready drops only once every stage holds a word.
`include "time_of_day_keeper_unit_assert.svh"

module time_of_day_keeper_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [4:0]         s_hour_value,
    input  logic [5:0]         s_minute_value,
    input  logic [5:0]         s_second_value,
    input  logic signed [31:0] s_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_hour_of_day,
    output logic [5:0]         m_minute_of_hour,
    output logic [5:0]         m_second_of_minute,
    output logic [16:0]        m_seconds_since_midnight,
    output logic [3:0]         m_clock12_hour,
    output logic [5:0]         m_rounded_minute,
    output logic               m_after_noon
);

    // handshake
    logic [todk_pkg::NSTG-1:0] vld_reg;
    logic [todk_pkg::NSTG-1:0] rdy;
    logic [todk_pkg::NSTG-1:0] take;
    logic                      out_rdy;
    logic                      m_valid_reg;

    // stage 0: magnitude and day quotient estimate
    todk_pkg::step_kind_t s0_kind;
    logic [30:0]          s0_a;
    logic [31:0]          s0_neg_amt;
    logic                 s0_big_neg;
    logic [48:0]          s0_prod;
    logic [4:0]           s0_ld_h;
    logic [5:0]           s0_ld_m;
    logic [5:0]           s0_ld_s;
    todk_pkg::step_kind_t p0_kind_reg;
    logic [30:0]          p0_a_reg;
    logic [14:0]          p0_q_reg;
    logic [4:0]           p0_ld_h_reg;
    logic [5:0]           p0_ld_m_reg;
    logic [5:0]           p0_ld_s_reg;

    // stage 1: remainder within the day
    logic [31:0]          s1_r_raw;
    logic [31:0]          s1_r;
    todk_pkg::step_kind_t p1_kind_reg;
    logic [16:0]          p1_r_reg;
    logic [4:0]           p1_ld_h_reg;
    logic [5:0]           p1_ld_m_reg;
    logic [5:0]           p1_ld_s_reg;

    // stage 2: total minutes
    logic [34:0]          s2_prod;
    todk_pkg::step_kind_t p2_kind_reg;
    logic [16:0]          p2_r_reg;
    logic [10:0]          p2_mt_reg;
    logic [4:0]           p2_ld_h_reg;
    logic [5:0]           p2_ld_m_reg;
    logic [5:0]           p2_ld_s_reg;

    // stage 3: seconds and hours
    logic [16:0]          s3_s;
    logic [28:0]          s3_prod;
    todk_pkg::step_kind_t p3_kind_reg;
    logic [10:0]          p3_mt_reg;
    logic [4:0]           p3_h_reg;
    logic [5:0]           p3_s_reg;
    logic [4:0]           p3_ld_h_reg;
    logic [5:0]           p3_ld_m_reg;
    logic [5:0]           p3_ld_s_reg;

    // stage 4: minutes, operand select
    logic [10:0]          s4_m;
    todk_pkg::step_kind_t p4_kind_reg;
    logic [4:0]           p4_h_reg;
    logic [5:0]           p4_m_reg;
    logic [5:0]           p4_s_reg;

    // stage 5: time of day
    logic [4:0]           hour_reg;
    logic [5:0]           minute_reg;
    logic [5:0]           second_reg;
    logic [4:0]           hour_next;
    logic [5:0]           minute_next;
    logic [5:0]           second_next;
    logic [6:0]           add_s;
    logic [6:0]           add_m;
    logic [5:0]           add_h;
    logic                 add_c1;
    logic                 add_c2;
    logic [6:0]           sub_s;
    logic [6:0]           sub_m;
    logic [5:0]           sub_h;

    // output stage
    logic [16:0]          o_sod;
    logic [6:0]           o_rm_sum;
    logic                 o_rm_carry;
    logic [5:0]           o_rm;
    logic [4:0]           o_rh_sum;
    logic [4:0]           o_rh;
    logic                 o_pm;
    logic [4:0]           o_h12_raw;
    logic [3:0]           o_h12;
    logic [4:0]           out_h_reg;
    logic [5:0]           out_m_reg;
    logic [5:0]           out_s_reg;
    logic [16:0]          out_sod_reg;
    logic [3:0]           out_h12_reg;
    logic [5:0]           out_rm_reg;
    logic                 out_pm_reg;

    // ---------------- handshake ----------------
    assign out_rdy = !m_valid_reg || m_ready;

    always_comb begin
        rdy[todk_pkg::NSTG-1] = !vld_reg[todk_pkg::NSTG-1] || out_rdy;
        for (int k = todk_pkg::NSTG - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        take[0] = rdy[0] && s_valid;
        for (int k = 1; k < todk_pkg::NSTG; k++) begin
            take[k] = rdy[k] && vld_reg[k-1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < todk_pkg::NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (out_rdy) begin
                m_valid_reg <= vld_reg[todk_pkg::NSTG-1];
            end
        end
    end

    // ---------------- stage 0 ----------------
    assign s0_neg_amt = 32'd0 - 32'(s_amount);
    assign s0_big_neg = s_amount < todk_pkg::SUB_LIMIT;
    assign s0_ld_h = (s_hour_value < 5'(todk_pkg::HOURS_PER_DAY)) ? s_hour_value : 5'd0;
    assign s0_ld_m = (s_minute_value < 6'(todk_pkg::SECS_PER_MINUTE)) ? s_minute_value : 6'd0;
    assign s0_ld_s = (s_second_value < 6'(todk_pkg::SECS_PER_MINUTE)) ? s_second_value : 6'd0;

    always_comb begin
        s0_kind = todk_pkg::KIND_HOLD;
        s0_a    = '0;
        unique case (s_operation)
            todk_pkg::OP_LOAD_HMS: begin
                s0_kind = todk_pkg::KIND_LOAD_HMS;
            end
            todk_pkg::OP_LOAD_CNT: begin
                s0_kind = todk_pkg::KIND_LOAD;
                s0_a    = s_amount[31] ? 31'd0 : s_amount[30:0];
            end
            todk_pkg::OP_ADVANCE: begin
                priority if (!s_amount[31]) begin
                    s0_kind = todk_pkg::KIND_ADD;
                    s0_a    = s_amount[30:0];
                end else if (s0_big_neg) begin
                    s0_kind = todk_pkg::KIND_LOAD;
                end else begin
                    s0_kind = todk_pkg::KIND_SUB;
                    s0_a    = s0_neg_amt[30:0];
                end
            end
            todk_pkg::OP_NONE: begin
                s0_kind = todk_pkg::KIND_HOLD;
            end
        endcase
    end

    assign s0_prod = 49'(s0_a[30:todk_pkg::DAY_PRE_SHIFT]) * 49'(todk_pkg::DAY_RECIP);

    always_ff @(posedge aclk) begin
        if (take[0]) begin
            p0_kind_reg <= s0_kind;
            p0_a_reg    <= s0_a;
            p0_q_reg    <= s0_prod[todk_pkg::DAY_DIV_SHIFT +: 15];
            p0_ld_h_reg <= s0_ld_h;
            p0_ld_m_reg <= s0_ld_m;
            p0_ld_s_reg <= s0_ld_s;
        end
    end

    // ---------------- stage 1 ----------------
    assign s1_r_raw = 32'(p0_a_reg) - 32'(p0_q_reg) * 32'(todk_pkg::SECS_PER_DAY);
    assign s1_r = (s1_r_raw >= 32'(todk_pkg::SECS_PER_DAY))
                ? s1_r_raw - 32'(todk_pkg::SECS_PER_DAY) : s1_r_raw;

    always_ff @(posedge aclk) begin
        if (take[1]) begin
            p1_kind_reg <= p0_kind_reg;
            p1_r_reg    <= s1_r[16:0];
            p1_ld_h_reg <= p0_ld_h_reg;
            p1_ld_m_reg <= p0_ld_m_reg;
            p1_ld_s_reg <= p0_ld_s_reg;
        end
    end

    // ---------------- stage 2 ----------------
    assign s2_prod = 35'(p1_r_reg) * 35'(todk_pkg::MIN_RECIP);

    always_ff @(posedge aclk) begin
        if (take[2]) begin
            p2_kind_reg <= p1_kind_reg;
            p2_r_reg    <= p1_r_reg;
            p2_mt_reg   <= s2_prod[todk_pkg::MIN_DIV_SHIFT +: 11];
            p2_ld_h_reg <= p1_ld_h_reg;
            p2_ld_m_reg <= p1_ld_m_reg;
            p2_ld_s_reg <= p1_ld_s_reg;
        end
    end

    // ---------------- stage 3 ----------------
    assign s3_s    = p2_r_reg - 17'(p2_mt_reg) * 17'(todk_pkg::SECS_PER_MINUTE);
    assign s3_prod = 29'(p2_mt_reg) * 29'(todk_pkg::MIN_RECIP);

    always_ff @(posedge aclk) begin
        if (take[3]) begin
            p3_kind_reg <= p2_kind_reg;
            p3_mt_reg   <= p2_mt_reg;
            p3_h_reg    <= s3_prod[todk_pkg::MIN_DIV_SHIFT +: 5];
            p3_s_reg    <= s3_s[5:0];
            p3_ld_h_reg <= p2_ld_h_reg;
            p3_ld_m_reg <= p2_ld_m_reg;
            p3_ld_s_reg <= p2_ld_s_reg;
        end
    end

    // ---------------- stage 4 ----------------
    assign s4_m = p3_mt_reg - 11'(p3_h_reg) * 11'(todk_pkg::SECS_PER_MINUTE);

    always_ff @(posedge aclk) begin
        if (take[4]) begin
            p4_kind_reg <= p3_kind_reg;
            if (p3_kind_reg == todk_pkg::KIND_LOAD_HMS) begin
                p4_h_reg <= p3_ld_h_reg;
                p4_m_reg <= p3_ld_m_reg;
                p4_s_reg <= p3_ld_s_reg;
            end else begin
                p4_h_reg <= p3_h_reg;
                p4_m_reg <= s4_m[5:0];
                p4_s_reg <= p3_s_reg;
            end
        end
    end

    // ---------------- stage 5: time registers ----------------
    // add with carries, wrap at one day
    assign add_s  = {1'b0, second_reg} + {1'b0, p4_s_reg};
    assign add_c1 = add_s >= 7'(todk_pkg::SECS_PER_MINUTE);
    assign add_m  = {1'b0, minute_reg} + {1'b0, p4_m_reg} + 7'(add_c1);
    assign add_c2 = add_m >= 7'(todk_pkg::SECS_PER_MINUTE);
    assign add_h  = {1'b0, hour_reg} + {1'b0, p4_h_reg} + 6'(add_c2);

    // subtract with borrows, clamp at midnight
    assign sub_s = {1'b0, second_reg} - {1'b0, p4_s_reg};
    assign sub_m = {1'b0, minute_reg} - {1'b0, p4_m_reg} - 7'(sub_s[6]);
    assign sub_h = {1'b0, hour_reg} - {1'b0, p4_h_reg} - 6'(sub_m[6]);

    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        unique case (p4_kind_reg)
            todk_pkg::KIND_HOLD: begin
                hour_next   = hour_reg;
            end
            todk_pkg::KIND_LOAD_HMS,
            todk_pkg::KIND_LOAD: begin
                hour_next   = p4_h_reg;
                minute_next = p4_m_reg;
                second_next = p4_s_reg;
            end
            todk_pkg::KIND_ADD: begin
                second_next = add_c1 ? 6'(add_s - 7'(todk_pkg::SECS_PER_MINUTE)) : add_s[5:0];
                minute_next = add_c2 ? 6'(add_m - 7'(todk_pkg::SECS_PER_MINUTE)) : add_m[5:0];
                hour_next   = (add_h >= 6'(todk_pkg::HOURS_PER_DAY))
                            ? 5'(add_h - 6'(todk_pkg::HOURS_PER_DAY)) : add_h[4:0];
            end
            todk_pkg::KIND_SUB: begin
                if (sub_h[5]) begin
                    hour_next   = 5'd0;
                    minute_next = 6'd0;
                    second_next = 6'd0;
                end else begin
                    second_next = sub_s[6] ? 6'(sub_s + 7'(todk_pkg::SECS_PER_MINUTE))
                                           : sub_s[5:0];
                    minute_next = sub_m[6] ? 6'(sub_m + 7'(todk_pkg::SECS_PER_MINUTE))
                                           : sub_m[5:0];
                    hour_next   = sub_h[4:0];
                end
            end
            default: begin
                hour_next   = hour_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg   <= 5'(todk_pkg::HOURS_PER_DAY - 1);
            minute_reg <= 6'(todk_pkg::SECS_PER_MINUTE - 1);
            second_reg <= 6'(todk_pkg::SECS_PER_MINUTE - 1);
        end else if (take[5]) begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    // ---------------- output stage ----------------
    assign o_sod = 17'(hour_reg) * 17'(todk_pkg::SECS_PER_HOUR)
                 + 17'(minute_reg) * 17'(todk_pkg::SECS_PER_MINUTE)
                 + 17'(second_reg);

    assign o_rm_sum   = {1'b0, minute_reg}
                      + 7'(second_reg >= 6'(todk_pkg::ROUND_UP_SECOND));
    assign o_rm_carry = o_rm_sum == 7'(todk_pkg::SECS_PER_MINUTE);
    assign o_rm       = o_rm_carry ? 6'd0 : o_rm_sum[5:0];
    assign o_rh_sum   = hour_reg + 5'(o_rm_carry);
    assign o_rh       = (o_rh_sum == 5'(todk_pkg::HOURS_PER_DAY)) ? 5'd0 : o_rh_sum;
    assign o_pm       = o_rh >= 5'(todk_pkg::HOURS_PER_HALF);
    assign o_h12_raw  = o_pm ? o_rh - 5'(todk_pkg::HOURS_PER_HALF) : o_rh;
    assign o_h12      = (o_h12_raw == 5'd0) ? 4'(todk_pkg::HOURS_PER_HALF) : o_h12_raw[3:0];

    always_ff @(posedge aclk) begin
        if (out_rdy && vld_reg[todk_pkg::NSTG-1]) begin
            out_h_reg   <= hour_reg;
            out_m_reg   <= minute_reg;
            out_s_reg   <= second_reg;
            out_sod_reg <= o_sod;
            out_h12_reg <= o_h12;
            out_rm_reg  <= o_rm;
            out_pm_reg  <= o_pm;
        end
    end

    assign m_hour_of_day            = out_h_reg;
    assign m_minute_of_hour         = out_m_reg;
    assign m_second_of_minute       = out_s_reg;
    assign m_seconds_since_midnight = out_sod_reg;
    assign m_clock12_hour           = out_h12_reg;
    assign m_rounded_minute         = out_rm_reg;
    assign m_after_noon             = out_pm_reg;

    // ---------------- assertions ----------------
    `TODK_ASSERT_ALWAYS(a_time_range, (hour_reg < 5'd24) && (minute_reg < 6'd60) && (second_reg < 6'd60), "time of day out of range")
    `TODK_ASSERT_IMPL(a_day_rem_range, vld_reg[1], p1_r_reg < 17'(todk_pkg::SECS_PER_DAY), "day remainder out of range")
    `TODK_ASSERT_IMPL(a_split_range, vld_reg[4], (p4_h_reg < 5'd24) && (p4_m_reg < 6'd60) && (p4_s_reg < 6'd60), "split operand out of range")
    `TODK_ASSERT_NEXT(a_time_hold, !take[5], $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg), "time changed without a word")
    `TODK_ASSERT_IMPL(a_out_source, $rose(m_valid_reg), $past(vld_reg[todk_pkg::NSTG-1]), "result without a word in the last stage")

endmodule
